// ===== src/binary_token_byte_fifo_unit_macros.svh =====
// Assertion macros for the binary token byte FIFO unit.
// Used by src/binary_token_byte_fifo_unit.sv; no other dependencies.
`ifndef BINARY_TOKEN_BYTE_FIFO_UNIT_MACROS_SVH
`define BINARY_TOKEN_BYTE_FIFO_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BTBF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define BTBF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define BTBF_ASSERT_SAME(label, ante, cons)
`define BTBF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/btbf_pkg.sv =====
// Package for the binary token byte FIFO unit: sizes, character codes,
// status and op codes, and the parser-to-FIFO struct. No dependencies.
`default_nettype none
package btbf_pkg;
	localparam int FIFO_DEPTH = 16;
	localparam int TOKEN_BITS = 8;
	localparam int WIN_LEN    = TOKEN_BITS + 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int POS_W      = $clog2(WIN_LEN + 1);

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_B    = 8'h62;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_PUSHED     = 3'd1,
		ST_FMT_ERR    = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_READ_OK    = 3'd4,
		ST_READ_EMPTY = 3'd5
	} btbf_status_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} btbf_op_t;

	typedef struct packed {
		logic                  term;
		logic                  ok;
		logic [TOKEN_BITS-1:0] value;
	} btbf_tok_t;
endpackage
`default_nettype wire

// ===== src/binary_token_byte_fifo_unit.sv =====
// Top level of the binary token byte FIFO unit: input register, token parser,
// byte FIFO and result register. Depends on btbf_pkg, btbf_token_parser, macros.
//
//  channel | dir | tdata                                        | tuser      | tlast
//  s_      | in  | [7:0] char_in                                | [0] op     | last
//  m_      | out | [7:0] parsed_value [15:8] read_data [20:16] fill_level | [2:0] status | -
//
// Path from input transaction to result: input register, then the parser decode
// and FIFO update feed the result register. One transaction per cycle sustained
// while m_ is not stalled; the FIFO pointers and count update with the result register.
// Reset clears window, pointers, count and both valid flags; FIFO bytes are not reset.
// Stalls on m_ back up through the input register to s_tready.
`default_nettype none
`include "binary_token_byte_fifo_unit_macros.svh"
module binary_token_byte_fifo_unit import btbf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	input  wire logic [0:0]  s_tuser,   // [0] op
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] parsed_value, [15:8] read_data, [20:16] fill_level
	output logic [2:0]       m_tuser    // [2:0] status
);
	logic             valid_s1;
	btbf_op_t         op_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	logic             valid_s2;
	btbf_status_t     status_s2;
	logic [7:0]       parsed_s2;
	logic [7:0]       rdata_s2;
	logic [CNT_W-1:0] fill_s2;

	logic [7:0]       mem [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic             adv;
	logic             step;
	btbf_tok_t        tok;
	logic             empty;
	logic             full;
	logic             do_push;
	logic             do_pop;
	btbf_status_t     status_nx;
	logic [7:0]       parsed_nx;
	logic [CNT_W-1:0] count_nx;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign step     = adv && (op_s1 == OP_WRITE);

	btbf_token_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (char_s1),
		.last    (last_s1),
		.tok     (tok)
	);

	always_comb begin
		empty     = (count_q == '0);
		full      = (count_q == CNT_W'(FIFO_DEPTH));
		do_push   = 1'b0;
		do_pop    = 1'b0;
		status_nx = ST_NONE;
		parsed_nx = '0;
		if (op_s1 == OP_READ) begin
			do_pop    = !empty;
			status_nx = empty ? ST_READ_EMPTY : ST_READ_OK;
		end else if (tok.term) begin
			if (tok.ok) begin
				parsed_nx = 8'(tok.value);
				do_push   = !full;
				status_nx = full ? ST_DROPPED : ST_PUSHED;
			end else begin
				status_nx = ST_FMT_ERR;
			end
		end
		count_nx = count_q;
		if (do_push) begin
			count_nx = count_q + 1'b1;
		end else if (do_pop) begin
			count_nx = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				count_q  <= count_nx;
				if (do_push) begin
					wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				end
				if (do_pop) begin
					rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				end
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= btbf_op_t'(s_tuser[0]);
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv) begin
			status_s2 <= status_nx;
			parsed_s2 <= parsed_nx;
			fill_s2   <= count_nx;
			rdata_s2  <= do_pop ? mem[rd_ptr_q] : '0;
		end
		if (adv && do_push) begin
			mem[wr_ptr_q] <= parsed_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {3'b000, fill_s2, rdata_s2, parsed_s2};

	`BTBF_ASSERT_SAME(a_ptr_match, count_q == '0 || count_q == CNT_W'(FIFO_DEPTH), rd_ptr_q == wr_ptr_q)
	`BTBF_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_W'(FIFO_DEPTH))
	`BTBF_ASSERT_SAME(a_push_fill, valid_s2 && status_s2 == ST_PUSHED, fill_s2 != '0)
	`BTBF_ASSERT_SAME(a_pop_fill, valid_s2 && status_s2 == ST_READ_OK, fill_s2 != CNT_W'(FIFO_DEPTH))
	`BTBF_ASSERT_NEXT(a_adv_count, adv && do_push, count_q == $past(count_q) + 1'b1)
endmodule
`default_nettype wire

// ===== src/btbf_token_parser.sv =====
// Token parser: keeps the character window of the current write and decodes
// a '0b' binary token at each terminator. Depends on btbf_pkg.
`default_nettype none
module btbf_token_parser import btbf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_in,
	input  wire logic       last,
	output btbf_tok_t       tok
);
	logic [7:0]       win_q [WIN_LEN];
	logic [POS_W-1:0] pos_q;
	logic             ended_q;
	logic             is_nul;
	logic             shift;

	always_comb begin
		is_nul = (char_in == CH_NUL);
		shift = !ended_q && !last && !is_nul;
		tok.term = !ended_q && (last || is_nul || char_in == CH_SEMI);
		tok.ok = (pos_q == POS_W'(WIN_LEN)) && (win_q[0] == CH_ZERO) && (win_q[1] == CH_B);
		for (int i = 0; i < TOKEN_BITS; i++) begin
			if (win_q[2+i] != CH_ZERO && win_q[2+i] != CH_ONE) begin
				tok.ok = 1'b0;
			end
			tok.value[TOKEN_BITS-1-i] = (win_q[2+i] == CH_ONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			pos_q   <= '0;
			ended_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				for (int i = 0; i < WIN_LEN; i++) begin
					win_q[i] <= '0;
				end
				pos_q   <= '0;
				ended_q <= 1'b0;
			end else if (!ended_q && is_nul) begin
				ended_q <= 1'b1;
			end else if (shift) begin
				for (int i = 0; i < WIN_LEN - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WIN_LEN-1] <= char_in;
				if (pos_q != POS_W'(WIN_LEN)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire
